FILE: sv/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the line pixel generator: request and pixel
// payloads, the classified line job, and field widths.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int COORD_W  = 6;
  localparam int COLOR_W  = 8;
  localparam int ADDR_W   = 12;
  localparam int HEIGHT_W = 7;
  // doubled deltas reach 126
  localparam int DELTA_W  = COORD_W + 1;
  // decision term stays within about +/-126 plus one step
  localparam int DEC_W    = COORD_W + 3;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd64;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] color;
  } request_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pixel_t;

  // one line, ready for the stepper
  typedef struct packed {
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic                    x_major;
    logic                    sx_neg;
    logic                    sy_neg;
    logic [DELTA_W-1:0]      dmaj;    // twice the major delta
    logic [DELTA_W-1:0]      dmin;    // twice the minor delta
    logic signed [DEC_W-1:0] d;       // initial decision term
    logic [COORD_W-1:0]      remain;  // pixels after the first
    logic [COLOR_W-1:0]      color;
  } job_t;

endpackage

FILE: sv/lpg_setup.sv
// ----------------------------------------------------------------------------
// lpg_setup
// Front end: takes a line request, works out deltas, directions, major axis,
// initial decision term and pixel count, and hands the job to the queue.
// ----------------------------------------------------------------------------
module lpg_setup #(
  parameter int MAX_SIDE = 64
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  lpg_pkg::request_t in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output lpg_pkg::job_t     job
);
  import lpg_pkg::*;

  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic [COORD_W-1:0]        adx;
  logic [COORD_W-1:0]        ady;
  logic                      x_major;
  logic [COORD_W-1:0]        major;
  logic [COORD_W-1:0]        minor;
  logic [COORD_W:0]          limit;

  // signed deltas and magnitudes
  assign dx  = $signed({1'b0, in_data.end_x}) - $signed({1'b0, in_data.start_x});
  assign dy  = $signed({1'b0, in_data.end_y}) - $signed({1'b0, in_data.start_y});
  assign adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  // ties step along y
  assign x_major = adx > ady;
  assign major   = x_major ? adx : ady;
  assign minor   = x_major ? ady : adx;
  assign limit   = (COORD_W + 1)'(MAX_SIDE - 1);

  // job fields
  always_comb begin
    job.x       = in_data.start_x;
    job.y       = in_data.start_y;
    job.x_major = x_major;
    job.sx_neg  = dx[COORD_W];
    job.sy_neg  = dy[COORD_W];
    job.dmaj    = {major, 1'b0};
    job.dmin    = {minor, 1'b0};
    job.d       = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    job.remain  = ({1'b0, major} > limit) ? limit[COORD_W-1:0] : major;
    job.color   = in_data.color;
  end

  assign job_valid = in_valid;
  assign in_ready  = job_ready;

endmodule

FILE: sv/lpg_fifo.sv
// ----------------------------------------------------------------------------
// lpg_fifo
// Two-entry job queue between the setup front end and the stepper.
// ----------------------------------------------------------------------------
module lpg_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  lpg_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output lpg_pkg::job_t rd_data
);
  import lpg_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = count != CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/lpg_stepper.sv
// ----------------------------------------------------------------------------
// lpg_stepper
// Back end: walks one line a pixel per cycle while the output is not stalled,
// using the Bresenham decision term, and loads each pixel, with its frame
// buffer address, into the output register.
// ----------------------------------------------------------------------------
module lpg_stepper (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [lpg_pkg::HEIGHT_W-1:0]     height,
  input  logic                             job_valid,
  output logic                             job_ready,
  input  lpg_pkg::job_t                    job,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lpg_pkg::pixel_t                  out_data
);
  import lpg_pkg::*;

  localparam int PROD_W = COORD_W + HEIGHT_W;

  logic                    active;
  job_t                    cur;
  logic                    emit;
  logic                    last;
  logic                    d_ge;
  logic [COORD_W-1:0]      x_step;
  logic [COORD_W-1:0]      y_step;
  logic [COORD_W-1:0]      x_next;
  logic [COORD_W-1:0]      y_next;
  logic signed [DEC_W-1:0] d_next;
  logic signed [DEC_W-1:0] dmaj_s;
  logic signed [DEC_W-1:0] dmin_s;
  logic [PROD_W-1:0]       addr_full;

  // handshake
  assign emit      = active && (!out_valid || out_ready);
  assign last      = cur.remain == '0;
  assign job_ready = !active || (emit && last);

  // next position and decision term
  assign d_ge   = !cur.d[DEC_W-1];
  assign dmaj_s = $signed({2'b00, cur.dmaj});
  assign dmin_s = $signed({2'b00, cur.dmin});
  assign x_step = cur.sx_neg ? cur.x - 1'b1 : cur.x + 1'b1;
  assign y_step = cur.sy_neg ? cur.y - 1'b1 : cur.y + 1'b1;

  always_comb begin
    if (cur.x_major) begin
      x_next = x_step;
      y_next = d_ge ? y_step : cur.y;
    end else begin
      x_next = d_ge ? x_step : cur.x;
      y_next = y_step;
    end
    d_next = (d_ge ? cur.d - dmaj_s : cur.d) + dmin_s;
  end

  // column-major address, wraps to the address width
  assign addr_full = PROD_W'(cur.x) * PROD_W'(height) + PROD_W'(cur.y);

  // job state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (job_valid && job_ready) begin
      active <= 1'b1;
    end else if (emit && last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur <= job;
    end else if (emit) begin
      cur.x      <= x_next;
      cur.y      <= y_next;
      cur.d      <= d_next;
      cur.remain <= cur.remain - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.pixel_x       <= cur.x;
      out_data.pixel_y       <= cur.y;
      out_data.pixel_address <= addr_full[ADDR_W-1:0];
      out_data.pixel_color   <= cur.color;
      out_data.last_pixel    <= last;
    end
  end

endmodule

FILE: sv/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// line_pixel_generator
// Bresenham line rasterizer: one line request in, one pixel result per cycle
// out unless the output stalls, each with its column-major frame buffer address.
// ----------------------------------------------------------------------------
// An accepted request passes through the job queue and the stepper's job
// register before its first pixel enters the output register.
// Throughput: one pixel per cycle unless the output stalls; the single stepper
// draws major delta + 1 pixels per line (at most MAX_SIDE); queued lines follow
// with no gap. Up to two requests wait in the job queue while a line is drawn.
// Reset (rst, synchronous): empties the queue and stepper, height returns to 64.
module line_pixel_generator #(
  parameter int MAX_SIDE = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lpg_pkg::request_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lpg_pkg::pixel_t              out_data,
  input  logic                         cfg_we,
  input  logic [lpg_pkg::HEIGHT_W-1:0] cfg_data
);
  import lpg_pkg::*;

  logic [HEIGHT_W-1:0] height;
  logic                setup_valid;
  logic                setup_ready;
  job_t                setup_job;
  logic                job_valid;
  logic                job_ready;
  job_t                job;

  // screen height register
  always_ff @(posedge clk) begin
    if (rst) begin
      height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      height <= cfg_data;
    end
  end

  // front end
  lpg_setup #(
    .MAX_SIDE (MAX_SIDE)
  ) u_setup (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (setup_valid),
    .job_ready (setup_ready),
    .job       (setup_job)
  );

  // job queue
  lpg_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (setup_valid),
    .wr_ready (setup_ready),
    .wr_data  (setup_job),
    .rd_valid (job_valid),
    .rd_ready (job_ready),
    .rd_data  (job)
  );

  // back end
  lpg_stepper u_stepper (
    .clk       (clk),
    .rst       (rst),
    .height    (height),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sv/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks for the line pixel generator: output handshake, reset,
// pixel adjacency within a line and address consistency.
// ----------------------------------------------------------------------------
module lpg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input lpg_pkg::pixel_t              out_data,
  input logic                         cfg_we,
  input logic [lpg_pkg::HEIGHT_W-1:0] cfg_data
);
  import lpg_pkg::*;

  localparam int PROD_W = COORD_W + HEIGHT_W;

  logic [HEIGHT_W-1:0] height;
  logic [COORD_W-1:0]  prev_x;
  logic [COORD_W-1:0]  prev_y;
  logic                prev_open;
  logic                x_adj;
  logic                y_adj;
  logic [PROD_W-1:0]   addr_full;

  // shadow of the height register
  always_ff @(posedge clk) begin
    if (rst) begin
      height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      height <= cfg_data;
    end
  end

  // last delivered pixel, and whether its line goes on
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_open <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_open <= !out_data.last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_x <= out_data.pixel_x;
      prev_y <= out_data.pixel_y;
    end
  end

  assign x_adj = (out_data.pixel_x == prev_x) || (out_data.pixel_x == prev_x + 1'b1) ||
                 (out_data.pixel_x == prev_x - 1'b1);
  assign y_adj = (out_data.pixel_y == prev_y) || (out_data.pixel_y == prev_y + 1'b1) ||
                 (out_data.pixel_y == prev_y - 1'b1);
  assign addr_full = PROD_W'(out_data.pixel_x) * PROD_W'(height) +
                     PROD_W'(out_data.pixel_y);

  // a stalled pixel stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel withdrawn while stalled");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pixel valid after reset");

  // consecutive pixels of one line are 8-neighbors
  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    out_valid && prev_open |-> x_adj && y_adj &&
      ((out_data.pixel_x != prev_x) || (out_data.pixel_y != prev_y)))
    else $error("pixel not adjacent to previous pixel of line");

  // address matches coordinates and height
  a_address: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pixel_address == addr_full[ADDR_W-1:0])
    else $error("pixel address mismatch");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (.*);

FILE: tb/sv/line_pixel_generator_tb.sv
// ----------------------------------------------------------------------------
// line_pixel_generator_tb
// Self-checking bench for the line rasterizer. Line requests are queued by the
// stimulus block and sent by a clocked driver. A clocked monitor expands each
// accepted request into the Bresenham pixels it should produce and checks
// every pixel against them, field by field. The run steps through several
// screen heights and through different sender and receiver gap patterns.
// ----------------------------------------------------------------------------
module line_pixel_generator_tb;
  import lpg_pkg::*;

  localparam int SIDE_LIMIT = 64;
  localparam int LONG_HOLD  = 300;
  localparam int NUM_PHASES = 7;
  // height per phase; the first phase keeps the reset value, -1 picks one at random
  localparam int PHASE_HEIGHT [NUM_PHASES] = '{64, 1, 127, 0, 64, 63, -1};
  localparam int PHASE_LINES  [NUM_PHASES] = '{0, 40, 40, 40, 40, 45, 45};

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  request_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  pixel_t              out_data;
  logic                cfg_we = 1'b0;
  logic [HEIGHT_W-1:0] cfg_data = '0;

  request_t            line_q[$];    // requests waiting to be sent
  pixel_t              pixel_q[$];   // pixels the block still owes
  logic [HEIGHT_W-1:0] height_model = HEIGHT_RESET;
  int                  errors = 0;
  int                  lines_sent = 0;
  int                  lines_taken = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_asked = 0;
  int                  hold_done = 0;
  int                  hold_left = 0;

  line_pixel_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic request_t line_req(int sx, int sy, int ex, int ey, int c);
    request_t r;
    r.start_x = sx[COORD_W-1:0];
    r.start_y = sy[COORD_W-1:0];
    r.end_x   = ex[COORD_W-1:0];
    r.end_y   = ey[COORD_W-1:0];
    r.color   = c[COLOR_W-1:0];
    return r;
  endfunction

  // expand one line request into its pixels, in drawing order
  function automatic void rasterize_line(request_t req);
    int x, y, dx, dy, ax, ay, sx, sy, d, count, addr;
    bit x_major;
    pixel_t pix;
    x = int'(req.start_x);
    y = int'(req.start_y);
    dx = int'(req.end_x) - x;
    dy = int'(req.end_y) - y;
    ax = 2 * (dx < 0 ? -dx : dx);
    ay = 2 * (dy < 0 ? -dy : dy);
    sx = dx < 0 ? -1 : 1;
    sy = dy < 0 ? -1 : 1;
    // ties step along y
    x_major = ax > ay;
    count = (x_major ? ax : ay) / 2 + 1;
    if (count > SIDE_LIMIT) count = SIDE_LIMIT;
    d = x_major ? (ay - ax / 2) : (ax - ay / 2);
    for (int i = 0; i < count; i++) begin
      addr = (x & 63) * int'(height_model) + (y & 63);
      pix.pixel_x       = x[COORD_W-1:0];
      pix.pixel_y       = y[COORD_W-1:0];
      pix.pixel_address = addr[ADDR_W-1:0];
      pix.pixel_color   = req.color;
      pix.last_pixel    = (i == count - 1);
      pixel_q.push_back(pix);
      if (x_major) begin
        if (d >= 0) begin
          y += sy;
          d -= ax;
        end
        x += sx;
        d += ay;
      end else begin
        if (d >= 0) begin
          x += sx;
          d -= ay;
        end
        y += sy;
        d += ax;
      end
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // random line: short ones most often, plus axis-aligned, diagonal and free lines
  function automatic request_t random_line();
    int kind, sx, sy, ex, ey, len;
    kind = $urandom_range(9);
    sx = $urandom_range(63);
    sy = $urandom_range(63);
    ex = $urandom_range(63);
    ey = $urandom_range(63);
    if (kind <= 3) begin
      ex = sx + $urandom_range(14) - 7;
      ey = sy + $urandom_range(14) - 7;
      ex = ex < 0 ? 0 : (ex > 63 ? 63 : ex);
      ey = ey < 0 ? 0 : (ey > 63 ? 63 : ey);
    end else if (kind == 4) begin
      ey = sy;
    end else if (kind == 5) begin
      ex = sx;
    end else if (kind == 6) begin
      len = $urandom_range(63);
      sx = $urandom_range(63 - len);
      sy = $urandom_range(63 - len);
      ex = sx + len;
      ey = sy + len;
      if ($urandom_range(1)) begin
        ex = sx;
        sx = sx + len;
      end
      if ($urandom_range(1)) begin
        ey = sy;
        sy = sy + len;
      end
    end
    return line_req(sx, sy, ex, ey, $urandom_range(255));
  endfunction

  task automatic write_height(input logic [HEIGHT_W-1:0] h);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    height_model = h;
  endtask

  // wait until all requests are sent and taken and every pixel is seen
  task automatic wait_idle();
    while (line_q.size() != 0 || lines_taken != lines_sent || pixel_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && lines_taken != lines_sent) begin
      // hold until taken
    end else if (line_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_data  <= line_q.pop_front();
      in_valid <= 1'b1;
      lines_sent++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // pixel receiver, with random gaps and an occasional long hold-off
  always @(negedge clk) begin
    if (hold_asked != hold_done) begin
      hold_done = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each accepted request, check each accepted pixel
  always @(posedge clk) begin
    pixel_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        rasterize_line(in_data);
        lines_taken++;
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, expected none, actual %p", $time, out_data);
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_x", want.pixel_x, out_data.pixel_x);
          check_field("pixel_y", want.pixel_y, out_data.pixel_y);
          check_field("pixel_address", want.pixel_address, out_data.pixel_address);
          check_field("pixel_color", want.pixel_color, out_data.pixel_color);
          check_field("last_pixel", want.last_pixel, out_data.last_pixel);
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      // gap pattern: receiver-heavy, then sender-heavy, then none
      if (ph < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 63;
      end else if (ph < 5) begin
        send_idle_pct = 63;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph != 0)
        write_height(HEIGHT_W'(PHASE_HEIGHT[ph] < 0 ? $urandom_range(127) : PHASE_HEIGHT[ph]));

      if (ph == 0) begin
        // single points, axis lines, diagonals, seven of the eight octants, short lines
        line_q.push_back(line_req(0, 0, 0, 0, 8'h00));
        line_q.push_back(line_req(63, 63, 63, 63, 8'hFF));
        line_q.push_back(line_req(0, 0, 63, 0, 8'h5A));
        line_q.push_back(line_req(63, 63, 0, 63, 8'hA5));
        line_q.push_back(line_req(0, 0, 0, 63, 8'h01));
        line_q.push_back(line_req(63, 63, 63, 0, 8'h80));
        line_q.push_back(line_req(0, 0, 63, 63, 8'h7F));
        line_q.push_back(line_req(63, 0, 0, 63, 8'hFE));
        line_q.push_back(line_req(0, 63, 63, 0, 8'h33));
        line_q.push_back(line_req(63, 63, 0, 0, 8'hCC));
        line_q.push_back(line_req(10, 20, 40, 25, 8'h2A));
        line_q.push_back(line_req(40, 25, 10, 20, 8'h15));
        line_q.push_back(line_req(10, 25, 40, 20, 8'h0F));
        line_q.push_back(line_req(40, 20, 10, 25, 8'hF0));
        line_q.push_back(line_req(20, 10, 25, 40, 8'h3C));
        line_q.push_back(line_req(25, 40, 20, 10, 8'hC3));
        line_q.push_back(line_req(20, 40, 25, 10, 8'h96));
        line_q.push_back(line_req(0, 0, 63, 62, 8'h69));
        line_q.push_back(line_req(0, 0, 62, 63, 8'hE7));
        line_q.push_back(line_req(5, 5, 6, 5, 8'h18));
        line_q.push_back(line_req(5, 5, 5, 6, 8'h81));
        line_q.push_back(line_req(0, 31, 63, 32, 8'h42));
      end else begin
        for (int i = 0; i < PHASE_LINES[ph]; i++)
          line_q.push_back(random_line());
      end

      // long receiver hold-off while requests keep coming
      if (ph == 2) hold_asked++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
